@@ rtl/a64as_pkg.sv @@
`timescale 1ns / 1ps
package a64as_pkg;

	// Register file geometry
	localparam int unsigned GpDepth  = 31;
	localparam int unsigned RegIdxW  = 5;
	localparam int unsigned DataW    = 64;
	localparam int unsigned FlagW    = 4;
	localparam logic [RegIdxW-1:0] ZrIdx = 5'd31;

	// Instruction form
	typedef enum logic [1:0] {
		CMD_IMM   = 2'd0,
		CMD_SHIFT = 2'd1,
		CMD_EXT   = 2'd2,
		CMD_CARRY = 2'd3
	} cmd_t;

	// Immediate shift selector
	localparam logic [1:0] IMM_NONE  = 2'b00;
	localparam logic [1:0] IMM_LSL12 = 2'b01;

	// Shifted-register shift kinds
	localparam logic [1:0] SHIFT_LSL = 2'b00;
	localparam logic [1:0] SHIFT_LSR = 2'b01;
	localparam logic [1:0] SHIFT_ASR = 2'b10;
	localparam logic [1:0] SHIFT_RSV = 2'b11;

	// Extend lengths (low two bits of the extend option)
	localparam logic [1:0] EXT_B = 2'b00;
	localparam logic [1:0] EXT_H = 2'b01;
	localparam logic [1:0] EXT_W = 2'b10;
	localparam logic [1:0] EXT_X = 2'b11;

	// Largest left shift after an extend
	localparam logic [5:0] EXT_MAX_LSL = 6'd4;

	// Flag bit positions
	localparam int unsigned FLAG_N = 3;
	localparam int unsigned FLAG_Z = 2;
	localparam int unsigned FLAG_C = 1;
	localparam int unsigned FLAG_V = 0;

	typedef struct packed {
		cmd_t               command;
		logic               is_sub;
		logic               set_flags;
		logic               wide;
		logic [1:0]         shift_kind;
		logic [11:0]        imm12;
		logic [5:0]         amount;
		logic [2:0]         extend_option;
		logic [RegIdxW-1:0] rm;
		logic [RegIdxW-1:0] rn;
		logic [RegIdxW-1:0] rd;
	} in_word_t;

	typedef struct packed {
		logic               reserved;
		logic [DataW-1:0]   value;
		logic [RegIdxW-1:0] dest;
		logic               dest_is_sp;
		logic               dest_written;
		logic [FlagW-1:0]   flags;
	} out_word_t;

endpackage

@@ rtl/a64as_if.sv @@
`timescale 1ns / 1ps
interface a64as_in_if;
	import a64as_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface a64as_out_if;
	import a64as_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/a64_add_sub_execute.sv @@
`timescale 1ns / 1ps
// A64 add/subtract execute unit. Takes one instruction word per cycle on req and returns one
// result word per instruction on rsp, in order. The accepting edge registers the fields and
// reads rn and rm from the 31-entry register file; a later edge runs the operand
// shift/extend, the 64-bit adder and the flag logic and loads the result register, from which
// the word is offered, as long as that register is empty or being drained. A held rsp stalls
// req through the same path. That adder stage sets the clock; a dependent instruction may
// follow in the very next cycle, since the result being retired is bypassed into the read
// registers. SP and NZCV live in flops. Reset clears every register (valid bits per entry),
// SP and NZCV at once; no clearing pass is needed. Register 31 reads as zero or SP and writes
// as SP or discards, per form. Reserved encodings return reserved=1 and change no state.
module a64_add_sub_execute (
	input logic           clk,
	input logic           arst_n,
	a64as_in_if.sink      req,
	a64as_out_if.source   rsp
);
	import a64as_pkg::*;

	// Stage 1 registers
	logic                  s1_valid_q;
	in_word_t              in_s1;
	logic [DataW-1:0]      rn_val_s1;
	logic [DataW-1:0]      rm_val_s1;
	logic                  rn_zero_s1;
	logic                  rm_zero_s1;

	// Architectural state
	logic [DataW-1:0]      gp_mem [GpDepth];
	logic [GpDepth-1:0]    gp_valid_q;
	logic [DataW-1:0]      sp_q;
	logic [FlagW-1:0]      nzcv_q;

	// Output register
	logic                  out_valid_q;
	out_word_t             out_q;

	// Compute stage signals
	logic                  s1_adv;
	logic                  accept;
	logic                  rsv_c;
	logic                  sp_dest_c;
	logic                  gp_wr_c;
	logic                  sp_wr_c;
	logic [DataW-1:0]      res_c;
	logic [FlagW-1:0]      new_flags_c;
	logic                  fwd_rn;
	logic                  fwd_rm;
	out_word_t             out_c;

	// Handshake: stage 1 moves on when the output register is free or being drained
	assign s1_adv   = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_adv;
	assign accept   = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Bypass the retiring result into the read registers
	assign fwd_rn = s1_adv && gp_wr_c && (in_s1.rd == req.data.rn);
	assign fwd_rm = s1_adv && gp_wr_c && (in_s1.rd == req.data.rm);

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	// Capture fields and read the register file
	always_ff @(posedge clk) begin
		if (accept) begin
			in_s1 <= req.data;
			if (fwd_rn) begin
				rn_val_s1 <= res_c;
			end else if (req.data.rn != ZrIdx) begin
				rn_val_s1 <= gp_mem[req.data.rn];
			end
			if (fwd_rm) begin
				rm_val_s1 <= res_c;
			end else if (req.data.rm != ZrIdx) begin
				rm_val_s1 <= gp_mem[req.data.rm];
			end
			rn_zero_s1 <= !fwd_rn && ((req.data.rn == ZrIdx) || !gp_valid_q[req.data.rn]);
			rm_zero_s1 <= !fwd_rm && ((req.data.rm == ZrIdx) || !gp_valid_q[req.data.rm]);
		end
	end

	// Decode, operand preparation, add and flags
	always_comb begin
		logic [DataW-1:0] mask;
		logic [DataW-1:0] x;
		logic [DataW-1:0] rm_full;
		logic [DataW-1:0] rm_m;
		logic [DataW-1:0] sext;
		logic [DataW-1:0] sh_val;
		logic [DataW-1:0] ext_val;
		logic [DataW-1:0] y;
		logic [DataW-1:0] y_op;
		logic [DataW-1:0] ovf_vec;
		logic [5:0]       shamt;
		logic             sp_ok;
		logic             cin;
		logic             carry;
		logic [DataW:0]   sum;

		mask = in_s1.wide ? {DataW{1'b1}} : {{(DataW/2){1'b0}}, {(DataW/2){1'b1}}};

		// Reserved encodings
		case (in_s1.command)
			CMD_IMM:   rsv_c = in_s1.shift_kind[1];
			CMD_SHIFT: rsv_c = (in_s1.shift_kind == SHIFT_RSV) ||
			                   (!in_s1.wide && in_s1.amount[5]);
			CMD_EXT:   rsv_c = in_s1.amount > EXT_MAX_LSL;
			default:   rsv_c = 1'b0;
		endcase

		sp_ok     = (in_s1.command == CMD_IMM) || (in_s1.command == CMD_EXT);
		sp_dest_c = sp_ok && !in_s1.set_flags;

		// First operand: register 31 is SP or zero by form
		if (in_s1.rn == ZrIdx) begin
			x = sp_ok ? (sp_q & mask) : '0;
		end else begin
			x = rn_zero_s1 ? '0 : (rn_val_s1 & mask);
		end

		// Second operand source
		rm_full = rm_zero_s1 ? '0 : rm_val_s1;
		rm_m    = rm_full & mask;

		// Shifted register
		shamt = in_s1.wide ? in_s1.amount : {1'b0, in_s1.amount[4:0]};
		sext  = in_s1.wide ? rm_m : {{(DataW/2){rm_m[DataW/2-1]}}, rm_m[DataW/2-1:0]};
		case (in_s1.shift_kind)
			SHIFT_LSL: sh_val = (rm_m << shamt) & mask;
			SHIFT_LSR: sh_val = rm_m >> shamt;
			SHIFT_ASR: sh_val = DataW'($signed(sext) >>> shamt) & mask;
			default:   sh_val = '0;
		endcase

		// Extended register
		case (in_s1.extend_option[1:0])
			EXT_B:   ext_val = {{(DataW-8){in_s1.extend_option[2] & rm_full[7]}},
			                    rm_full[7:0]};
			EXT_H:   ext_val = {{(DataW-16){in_s1.extend_option[2] & rm_full[15]}},
			                    rm_full[15:0]};
			EXT_W:   ext_val = {{(DataW-32){in_s1.extend_option[2] & rm_full[31]}},
			                    rm_full[31:0]};
			default: ext_val = rm_full;
		endcase
		ext_val = (ext_val << in_s1.amount[2:0]) & mask;

		// Second operand by form
		case (in_s1.command)
			CMD_IMM:   y = (in_s1.shift_kind == IMM_LSL12) ?
			               {{(DataW-24){1'b0}}, in_s1.imm12, 12'b0} :
			               {{(DataW-12){1'b0}}, in_s1.imm12};
			CMD_SHIFT: y = sh_val;
			CMD_EXT:   y = ext_val;
			default:   y = rm_m;
		endcase

		y_op = in_s1.is_sub ? (~y & mask) : y;
		cin  = (in_s1.command == CMD_CARRY) ? nzcv_q[FLAG_C] : in_s1.is_sub;

		// Add
		sum   = {1'b0, x} + {1'b0, y_op} + {{DataW{1'b0}}, cin};
		res_c = sum[DataW-1:0] & mask;
		carry = in_s1.wide ? sum[DataW] : sum[DataW/2];

		// Flags
		ovf_vec = (x ^ res_c) & (y_op ^ res_c);
		new_flags_c[FLAG_N] = in_s1.wide ? res_c[DataW-1] : res_c[DataW/2-1];
		new_flags_c[FLAG_Z] = (res_c == '0);
		new_flags_c[FLAG_C] = carry;
		new_flags_c[FLAG_V] = in_s1.wide ? ovf_vec[DataW-1] : ovf_vec[DataW/2-1];

		// Destination
		gp_wr_c = !rsv_c && (in_s1.rd != ZrIdx);
		sp_wr_c = !rsv_c && (in_s1.rd == ZrIdx) && sp_dest_c;

		// Result word
		if (rsv_c) begin
			out_c.reserved     = 1'b1;
			out_c.value        = '0;
			out_c.dest         = '0;
			out_c.dest_is_sp   = 1'b0;
			out_c.dest_written = 1'b0;
			out_c.flags        = nzcv_q;
		end else begin
			out_c.reserved     = 1'b0;
			out_c.value        = res_c;
			out_c.dest         = in_s1.rd;
			out_c.dest_is_sp   = sp_wr_c;
			out_c.dest_written = gp_wr_c || sp_wr_c;
			out_c.flags        = in_s1.set_flags ? new_flags_c : nzcv_q;
		end
	end

	// Register file write
	always_ff @(posedge clk) begin
		if (s1_adv && gp_wr_c) begin
			gp_mem[in_s1.rd] <= res_c;
		end
	end

	// Valid bits, SP and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_valid_q <= '0;
			sp_q       <= '0;
			nzcv_q     <= '0;
		end else if (s1_adv) begin
			if (gp_wr_c) begin
				gp_valid_q[in_s1.rd] <= 1'b1;
			end
			if (sp_wr_c) begin
				sp_q <= res_c;
			end
			if (!rsv_c && in_s1.set_flags) begin
				nzcv_q <= new_flags_c;
			end
		end
	end

	// Output register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= out_c;
		end
	end

	// Checks
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |-> !s1_adv)
		else $error("stage 1 advanced into a held output word");

	a_wr_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && gp_wr_c |=> gp_valid_q[$past(in_s1.rd)])
		else $error("written register not marked valid");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && (rsv_c || !in_s1.set_flags) |=> $stable(nzcv_q))
		else $error("flags changed without a flag-setting instruction");

	a_rsv_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.reserved |-> !out_q.dest_written && (out_q.value == '0))
		else $error("reserved word reports a write");

	a_sp_dest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.dest_is_sp |-> out_q.dest_written && (out_q.dest == ZrIdx))
		else $error("SP write without destination 31");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import a64as_pkg::*;

	// Immediate shift selectors that the architecture leaves reserved
	localparam logic [1:0] IMM_RSV_A = 2'b10;
	localparam logic [1:0] IMM_RSV_B = 2'b11;
	// Sign bit of the extend option
	localparam logic SGN = 1'b1;
	localparam logic UNS = 1'b0;
	localparam int SendSide = 0;
	localparam int RecvSide = 1;
	localparam int RandomWords = 1850;

	logic clk;
	logic arst_n;

	a64as_in_if  req_ch ();
	a64as_out_if rsp_ch ();

	a64_add_sub_execute i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Architectural state as the predictor sees it
	logic [DataW-1:0] gpr_file [GpDepth];
	logic [DataW-1:0] sp_value;
	logic [FlagW-1:0] nzcv_state;

	in_word_t  pending_words [$];
	out_word_t expected_results [$];
	out_word_t want_word;
	int        fail_count = 0;
	int        send_gap = 0;
	int        stall_left = 0;
	int        calm_left [2];
	logic      word_taken = 1'b0;

	always #1 clk = ~clk;

	function automatic logic [DataW-1:0] read_gpr(logic [RegIdxW-1:0] idx, logic sp_ok);
		if (idx == ZrIdx)
			return sp_ok ? sp_value : '0;
		return gpr_file[idx];
	endfunction

	// Execute one add/subtract word against the shadow state
	function automatic out_word_t execute_add_sub(in_word_t w);
		out_word_t        r;
		logic [DataW-1:0] mask, sign, x, y, rm_val, ext, res;
		logic [DataW:0]   sum;
		logic             rsv, sp_dest, carry_in, carry;
		mask = w.wide ? '1 : 64'h0000_0000_FFFF_FFFF;
		sign = w.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
		rsv = 1'b0;
		sp_dest = 1'b0;
		r = '0;
		case (w.command)
		CMD_IMM: begin
			rsv = (w.shift_kind != IMM_NONE) && (w.shift_kind != IMM_LSL12);
		end
		CMD_SHIFT: begin
			rsv = (w.shift_kind == SHIFT_RSV) || (!w.wide && w.amount[5]);
		end
		CMD_EXT: begin
			rsv = w.amount > EXT_MAX_LSL;
		end
		default: ;
		endcase
		// reserved: report current flags, touch nothing
		if (rsv) begin
			r.reserved = 1'b1;
			r.flags = nzcv_state;
			return r;
		end

		rm_val = read_gpr(w.rm, 1'b0);
		case (w.command)
		CMD_IMM: begin
			x = read_gpr(w.rn, 1'b1) & mask;
			y = (w.shift_kind == IMM_LSL12) ? {40'b0, w.imm12, 12'b0} : {52'b0, w.imm12};
			sp_dest = !w.set_flags;
		end
		CMD_SHIFT: begin
			x = read_gpr(w.rn, 1'b0) & mask;
			case (w.shift_kind)
			SHIFT_LSL: y = (rm_val & mask) << w.amount;
			SHIFT_LSR: y = (rm_val & mask) >> w.amount;
			default: begin
				if (w.wide)
					y = 64'($signed(rm_val) >>> w.amount);
				else
					y = {32'b0, 32'($signed(rm_val[31:0]) >>> w.amount)};
			end
			endcase
			y = y & mask;
		end
		CMD_EXT: begin
			x = read_gpr(w.rn, 1'b1) & mask;
			case (w.extend_option[1:0])
			EXT_B: ext = {{56{w.extend_option[2] & rm_val[7]}}, rm_val[7:0]};
			EXT_H: ext = {{48{w.extend_option[2] & rm_val[15]}}, rm_val[15:0]};
			EXT_W: ext = {{32{w.extend_option[2] & rm_val[31]}}, rm_val[31:0]};
			default: ext = rm_val;
			endcase
			y = (ext << w.amount[2:0]) & mask;
			sp_dest = !w.set_flags;
		end
		default: begin
			x = read_gpr(w.rn, 1'b0) & mask;
			y = rm_val & mask;
		end
		endcase

		// add with carry-in; subtract is add of the inverse plus one (or C)
		if (w.is_sub)
			y = ~y & mask;
		carry_in = (w.command == CMD_CARRY) ? nzcv_state[FLAG_C] : w.is_sub;
		sum = {1'b0, x} + {1'b0, y} + {64'b0, carry_in};
		res = sum[DataW-1:0] & mask;
		carry = w.wide ? sum[64] : sum[32];
		if (w.set_flags) begin
			nzcv_state[FLAG_N] = |(res & sign);
			nzcv_state[FLAG_Z] = (res == '0);
			nzcv_state[FLAG_C] = carry;
			nzcv_state[FLAG_V] = |((x ^ res) & (y ^ res) & sign);
		end

		// write back: register 31 is SP or the zero register
		r.value = res;
		r.dest = w.rd;
		if (w.rd == ZrIdx) begin
			if (sp_dest) begin
				sp_value = res;
				r.dest_is_sp = 1'b1;
				r.dest_written = 1'b1;
			end
		end else begin
			gpr_file[w.rd] = res;
			r.dest_written = 1'b1;
		end
		r.flags = nzcv_state;
		return r;
	endfunction

	function automatic in_word_t encode_add_sub(cmd_t cmd, logic sub, logic sf, logic wide,
			logic [1:0] kind, logic [11:0] imm, logic [5:0] amt, logic [2:0] opt,
			logic [4:0] rm, logic [4:0] rn, logic [4:0] rd);
		in_word_t w;
		w.command = cmd;
		w.is_sub = sub;
		w.set_flags = sf;
		w.wide = wide;
		w.shift_kind = kind;
		w.imm12 = imm;
		w.amount = amt;
		w.extend_option = opt;
		w.rm = rm;
		w.rn = rn;
		w.rd = rd;
		return w;
	endfunction

	// Favor a few hot registers and register 31 so results feed each other
	function automatic logic [RegIdxW-1:0] pick_reg();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return RegIdxW'($urandom_range(0, 3));
		if (roll == 4)
			return ZrIdx;
		return RegIdxW'($urandom_range(0, 31));
	endfunction

	// Mostly legal instructions with random content, some raw noise
	function automatic in_word_t random_word();
		logic [63:0] raw;
		in_word_t w;
		raw = {$urandom, $urandom};
		w = raw[$bits(in_word_t)-1:0];
		if ($urandom_range(0, 99) < 8)
			return w;
		w.command = cmd_t'(2'($urandom_range(0, 3)));
		w.rm = pick_reg();
		w.rn = pick_reg();
		w.rd = pick_reg();
		case (w.command)
		CMD_IMM: w.shift_kind[1] = 1'b0;
		CMD_SHIFT: begin
			if (w.shift_kind == SHIFT_RSV)
				w.shift_kind = 2'($urandom_range(0, 2));
			if (!w.wide)
				w.amount[5] = 1'b0;
		end
		CMD_EXT: w.amount = 6'($urandom_range(0, 4));
		default: ;
		endcase
		return w;
	endfunction

	// Gap length: mostly none or short, a few long, with calm stretches
	function automatic int next_gap(int side);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm_left[side] > 0) begin
			calm_left[side] = calm_left[side] - 1;
			return 0;
		end
		if (roll < 5) begin
			calm_left[side] = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Drive request words at the falling edge; hold each until taken
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || word_taken)) begin
			if (send_gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_words.size() > 0) begin
				req_ch.data <= pending_words.pop_front();
				req_ch.valid <= 1'b1;
				send_gap <= next_gap(SendSide);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left <= next_gap(RecvSide);
			end
		end
	end

	// Check results against the oldest prediction, then predict new words
	always @(posedge clk) begin
		if (arst_n) begin
			word_taken = req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result word with nothing expected: expected none, actual %h",
						$time, rsp_ch.data);
					fail_count++;
				end else begin
					want_word = expected_results.pop_front();
					check_field("reserved", 64'(want_word.reserved), 64'(rsp_ch.data.reserved));
					check_field("value", want_word.value, rsp_ch.data.value);
					check_field("dest", 64'(want_word.dest), 64'(rsp_ch.data.dest));
					check_field("dest_is_sp", 64'(want_word.dest_is_sp),
						64'(rsp_ch.data.dest_is_sp));
					check_field("dest_written", 64'(want_word.dest_written),
						64'(rsp_ch.data.dest_written));
					check_field("flags", 64'(want_word.flags), 64'(rsp_ch.data.flags));
				end
			end
			if (word_taken)
				expected_results.push_back(execute_add_sub(req_ch.data));
		end
	end

	// Hard stop
	initial begin
		#2000000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		calm_left[SendSide] = 0;
		calm_left[RecvSide] = 0;
		for (int i = 0; i < GpDepth; i++)
			gpr_file[i] = '0;
		sp_value = '0;
		nzcv_state = '0;

		// directed: operand extremes, SP and zero register, reserved encodings
		pending_words.push_back(encode_add_sub(CMD_IMM, 0, 0, 1, IMM_NONE, 12'hFFF, 0,
			0, 0, ZrIdx, 0));
		pending_words.push_back(encode_add_sub(CMD_IMM, 0, 0, 1, IMM_LSL12, 12'hFFF, 0,
			0, 0, 0, 1));
		pending_words.push_back(encode_add_sub(CMD_SHIFT, 1, 1, 1, SHIFT_LSL, 0, 0,
			0, 1, ZrIdx, 2));
		pending_words.push_back(encode_add_sub(CMD_SHIFT, 0, 0, 1, SHIFT_LSL, 0, 63,
			0, 2, ZrIdx, 3));
		pending_words.push_back(encode_add_sub(CMD_SHIFT, 0, 0, 1, SHIFT_ASR, 0, 63,
			0, 2, ZrIdx, 4));
		pending_words.push_back(encode_add_sub(CMD_SHIFT, 0, 1, 1, SHIFT_LSR, 0, 63,
			0, 4, 4, 5));
		pending_words.push_back(encode_add_sub(CMD_SHIFT, 0, 1, 0, SHIFT_ASR, 0, 31,
			0, 2, 3, 6));
		pending_words.push_back(encode_add_sub(CMD_SHIFT, 1, 1, 1, SHIFT_LSL, 0, 0,
			0, 3, ZrIdx, 7));
		pending_words.push_back(encode_add_sub(CMD_SHIFT, 0, 0, 1, SHIFT_RSV, 0, 1,
			0, 1, 1, 8));
		pending_words.push_back(encode_add_sub(CMD_SHIFT, 0, 0, 0, SHIFT_LSL, 0, 32,
			0, 1, 1, 8));
		pending_words.push_back(encode_add_sub(CMD_IMM, 0, 0, 1, IMM_RSV_A, 12'h001, 0,
			0, 0, 0, 8));
		pending_words.push_back(encode_add_sub(CMD_IMM, 0, 1, 0, IMM_RSV_B, 12'h001, 0,
			0, 0, 0, 8));
		pending_words.push_back(encode_add_sub(CMD_IMM, 1, 0, 1, IMM_NONE, 12'd16, 0,
			0, 0, ZrIdx, ZrIdx));
		pending_words.push_back(encode_add_sub(CMD_IMM, 1, 1, 1, IMM_NONE, 12'd1, 0,
			0, 0, ZrIdx, ZrIdx));
		pending_words.push_back(encode_add_sub(CMD_IMM, 0, 0, 0, IMM_LSL12, 12'h800, 0,
			0, 0, ZrIdx, ZrIdx));
		pending_words.push_back(encode_add_sub(CMD_EXT, 0, 0, 1, 0, 0, 4,
			{SGN, EXT_B}, 2, ZrIdx, ZrIdx));
		pending_words.push_back(encode_add_sub(CMD_EXT, 1, 1, 1, 0, 0, 0,
			{SGN, EXT_X}, 4, ZrIdx, ZrIdx));
		pending_words.push_back(encode_add_sub(CMD_EXT, 0, 0, 0, 0, 0, 2,
			{SGN, EXT_W}, 2, 1, 8));
		pending_words.push_back(encode_add_sub(CMD_EXT, 0, 0, 1, 0, 0, 1,
			{UNS, EXT_H}, 2, 0, 9));
		pending_words.push_back(encode_add_sub(CMD_EXT, 0, 0, 1, 0, 0, 3,
			{UNS, EXT_B}, ZrIdx, 2, 12));
		pending_words.push_back(encode_add_sub(CMD_EXT, 0, 0, 1, 0, 0, 5,
			{UNS, EXT_X}, 1, 1, 8));
		pending_words.push_back(encode_add_sub(CMD_EXT, 1, 1, 0, 0, 0, 63,
			{SGN, EXT_H}, 1, 1, 8));
		pending_words.push_back(encode_add_sub(CMD_CARRY, 0, 1, 1, 0, 0, 0,
			0, 4, 4, 10));
		pending_words.push_back(encode_add_sub(CMD_CARRY, 1, 1, 0, 0, 0, 0,
			0, 1, ZrIdx, 11));
		pending_words.push_back(encode_add_sub(CMD_CARRY, 0, 0, 1, 0, 0, 0,
			0, ZrIdx, ZrIdx, ZrIdx));

		for (int i = 0; i < RandomWords; i++)
			pending_words.push_back(random_word());

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all words sent and every prediction matched
		while (pending_words.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0 && expected_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
